/* sv/uoi_pkg.sv */
// ----------------------------------------------------------------------------
// uoi_pkg - shared types and constants for the unicycle odometry integrator
// Fixed-point widths, CORDIC table, payload structs and controller commands.
// ----------------------------------------------------------------------------
package uoi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int POS_WIDTH    = 32;

  // the arctangent table has 24 entries
  localparam int CORDIC_ITER = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int ITER_W      = $clog2(CORDIC_ITER);

  // CORDIC vector width: Q2.30 plus growth and sign
  localparam int CW    = 34;
  localparam int ACC_W = 64;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  // round(2^15/pi * 2^16) split into 16-bit halves for the 18-bit multiplier
  localparam logic [17:0] RAD_HI = 18'd10430;
  localparam logic [17:0] RAD_LO = 18'd24796;

  localparam logic [15:0] STEP_TIME_RESET = 16'd1311;

  localparam logic signed [ACC_W-1:0] POS_RND = 64'sd1 <<< 37;
  localparam logic signed [ACC_W-1:0] YAW_RND = 64'sd1 <<< 43;

  typedef struct packed {
    logic signed [15:0] lin_velocity;
    logic signed [15:0] yaw_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_item_t;

  typedef enum logic [3:0] {
    MS_NONE,
    MS_V_DT,
    MS_W_DT,
    MS_DV_CHI,
    MS_DV_CLO,
    MS_DV_SHI,
    MS_DV_SLO,
    MS_DW_KHI,
    MS_DW_KLO
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD_HI,
    ACC_ADD_LO
  } acc_op_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_DV,
    UPD_DW,
    UPD_X,
    UPD_Y,
    UPD_YAW,
    UPD_OUT
  } upd_op_t;

  typedef struct packed {
    logic     in_load;
    logic     cordic_start;
    logic     ang_half;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    upd_op_t  upd_op;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_busy;
    logic out_free;
  } dp_status_t;

  // atan(2^-i) as a 32-bit binary angle (2^32 = 2*pi)
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051E;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F61E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2F;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2F9;
      5'd15: r = 32'h0000_517C;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A2F;
      5'd19: r = 32'h0000_0517;
      5'd20: r = 32'h0000_028B;
      5'd21: r = 32'h0000_0145;
      5'd22: r = 32'h0000_00A2;
      5'd23: r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

/* sv/uoi_cordic.sv */
// ----------------------------------------------------------------------------
// uoi_cordic - iterative rotation-mode CORDIC
// One micro-rotation per cycle; gives cos/sin in Q2.30, held until next start.
// ----------------------------------------------------------------------------
module uoi_cordic
  import uoi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          angle,
  output logic                 busy,
  output logic signed [CW-1:0] cos_q30,
  output logic signed [CW-1:0] sin_q30
);

  localparam logic [ITER_W-1:0] LAST = ITER_W'(CORDIC_ITER - 1);

  logic [ITER_W-1:0]    cnt;
  logic signed [CW-1:0] x, y, z;
  logic                 flip;

  logic [31:0]          ang_q;
  logic [31:0]          ang_fold;
  logic signed [CW-1:0] xs, ys, at;

  // fold into the right half plane, undo with a sign flip at the end
  assign ang_q    = angle + 32'h4000_0000;
  assign ang_fold = angle ^ {ang_q[31], 31'd0};

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = CW'(atan_bam(5'(cnt)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == LAST) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= GAIN_Q30;
      y    <= '0;
      z    <= CW'($signed(ang_fold));
      flip <= ang_q[31];
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign cos_q30 = flip ? -x : x;
  assign sin_q30 = flip ? -y : y;

endmodule

/* sv/uoi_datapath.sv */
// ----------------------------------------------------------------------------
// uoi_datapath - pose registers, shared multiplier, accumulator, CORDIC
// Executes one controller command per cycle; holds the output register.
// ----------------------------------------------------------------------------
module uoi_datapath
  import uoi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [15:0] cfg_data
);

  logic [15:0]                 step_time;
  logic signed [POS_WIDTH-1:0] x_acc, y_acc;
  logic [15:0]                 yaw;

  in_item_t                    in_reg;
  logic signed [32:0]          dv, dw;
  logic signed [51:0]          prod;
  logic signed [ACC_W-1:0]     acc;
  out_item_t                   out_reg;

  logic signed [33:0]          mul_a;
  logic signed [17:0]          mul_b;
  logic signed [ACC_W-1:0]     acc_rnd_p, acc_rnd_q;
  logic signed [25:0]          dpos;
  logic [31:0]                 cordic_angle;
  logic                        cordic_busy;
  logic signed [CW-1:0]        cos_q30, sin_q30;
  logic signed [17:0]          dt_b;

  function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + CW'(32768)) >>> 16;
    if (r > CW'(16384)) begin
      r = CW'(16384);
    end else if (r < -CW'(16384)) begin
      r = -CW'(16384);
    end
    return r[15:0];
  endfunction

  assign cordic_angle = cmd.ang_half ? {yaw[15], yaw, 15'd0} : {yaw, 16'd0};

  uoi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.cordic_start),
    .angle   (cordic_angle),
    .busy    (cordic_busy),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  assign dt_b = $signed({2'b00, step_time});

  // operand select for the 34x18 multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_V_DT: begin
        mul_a = 34'(in_reg.lin_velocity);
        mul_b = dt_b;
      end
      MS_W_DT: begin
        mul_a = 34'(in_reg.yaw_rate);
        mul_b = dt_b;
      end
      MS_DV_CHI: begin
        mul_a = 34'(dv);
        mul_b = cos_q30[33:16];
      end
      MS_DV_CLO: begin
        mul_a = 34'(dv);
        mul_b = $signed({2'b00, cos_q30[15:0]});
      end
      MS_DV_SHI: begin
        mul_a = 34'(dv);
        mul_b = sin_q30[33:16];
      end
      MS_DV_SLO: begin
        mul_a = 34'(dv);
        mul_b = $signed({2'b00, sin_q30[15:0]});
      end
      MS_DW_KHI: begin
        mul_a = 34'(dw);
        mul_b = $signed(RAD_HI);
      end
      MS_DW_KLO: begin
        mul_a = 34'(dw);
        mul_b = $signed(RAD_LO);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_rnd_p = acc + POS_RND;
  assign acc_rnd_q = acc + YAW_RND;
  assign dpos      = acc_rnd_p[63:38];

  // pose state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= STEP_TIME_RESET;
      x_acc     <= '0;
      y_acc     <= '0;
      yaw       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_time <= cfg_data;
      end
      case (cmd.upd_op)
        UPD_X:   x_acc <= x_acc + POS_WIDTH'(dpos);
        UPD_Y:   y_acc <= y_acc + POS_WIDTH'(dpos);
        UPD_YAW: yaw   <= yaw + acc_rnd_q[59:44];
        default: ;
      endcase
      if (cmd.upd_op == UPD_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      in_reg <= in_data;
    end
    if (cmd.mul_sel != MS_NONE) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      ACC_LOAD_HI: acc <= ACC_W'(prod) <<< 16;
      ACC_ADD_LO:  acc <= acc + ACC_W'(prod);
      default: ;
    endcase
    case (cmd.upd_op)
      UPD_DV: dv <= prod[32:0];
      UPD_DW: dw <= prod[32:0];
      UPD_OUT: begin
        out_reg.pos_x   <= 32'(x_acc);
        out_reg.pos_y   <= 32'(y_acc);
        out_reg.heading <= yaw;
        out_reg.quat_z  <= to_q14(sin_q30);
        out_reg.quat_w  <= to_q14(cos_q30);
      end
      default: ;
    endcase
  end

  assign out_data           = out_reg;
  assign status.cordic_busy = cordic_busy;
  assign status.out_free    = !out_valid || !out_stall;

endmodule

/* sv/uoi_ctrl.sv */
// ----------------------------------------------------------------------------
// uoi_ctrl - sequencer for one odometry tick
// Steps the datapath through CORDIC, multiply-accumulate and output write.
// ----------------------------------------------------------------------------
module uoi_ctrl
  import uoi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'h0001,
    S_WAIT_C1 = 14'h0002,
    S_M_VDT   = 14'h0004,
    S_M_WDT   = 14'h0008,
    S_M_CHI   = 14'h0010,
    S_M_CLO   = 14'h0020,
    S_M_SHI   = 14'h0040,
    S_M_SLO   = 14'h0080,
    S_M_KHI   = 14'h0100,
    S_M_KLO   = 14'h0200,
    S_K_ADD   = 14'h0400,
    S_UPD_YAW = 14'h0800,
    S_START2  = 14'h1000,
    S_WAIT_C2 = 14'h2000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // product is registered, so acc/upd ops use it in the state after its multiply
  always_comb begin
    state_next       = state;
    cmd.in_load      = 1'b0;
    cmd.cordic_start = 1'b0;
    cmd.ang_half     = 1'b0;
    cmd.mul_sel      = MS_NONE;
    cmd.acc_op       = ACC_NONE;
    cmd.upd_op       = UPD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load      = 1'b1;
          cmd.cordic_start = 1'b1;
          state_next       = S_WAIT_C1;
        end
      end
      S_WAIT_C1: begin
        if (!status.cordic_busy) begin
          state_next = S_M_VDT;
        end
      end
      S_M_VDT: begin
        cmd.mul_sel = MS_V_DT;
        state_next  = S_M_WDT;
      end
      S_M_WDT: begin
        cmd.mul_sel = MS_W_DT;
        cmd.upd_op  = UPD_DV;
        state_next  = S_M_CHI;
      end
      S_M_CHI: begin
        cmd.mul_sel = MS_DV_CHI;
        cmd.upd_op  = UPD_DW;
        state_next  = S_M_CLO;
      end
      S_M_CLO: begin
        cmd.mul_sel = MS_DV_CLO;
        cmd.acc_op  = ACC_LOAD_HI;
        state_next  = S_M_SHI;
      end
      S_M_SHI: begin
        cmd.mul_sel = MS_DV_SHI;
        cmd.acc_op  = ACC_ADD_LO;
        state_next  = S_M_SLO;
      end
      S_M_SLO: begin
        cmd.mul_sel = MS_DV_SLO;
        cmd.acc_op  = ACC_LOAD_HI;
        cmd.upd_op  = UPD_X;
        state_next  = S_M_KHI;
      end
      S_M_KHI: begin
        cmd.mul_sel = MS_DW_KHI;
        cmd.acc_op  = ACC_ADD_LO;
        state_next  = S_M_KLO;
      end
      S_M_KLO: begin
        cmd.mul_sel = MS_DW_KLO;
        cmd.acc_op  = ACC_LOAD_HI;
        cmd.upd_op  = UPD_Y;
        state_next  = S_K_ADD;
      end
      S_K_ADD: begin
        cmd.acc_op = ACC_ADD_LO;
        state_next = S_UPD_YAW;
      end
      S_UPD_YAW: begin
        cmd.upd_op = UPD_YAW;
        state_next = S_START2;
      end
      S_START2: begin
        cmd.cordic_start = 1'b1;
        cmd.ang_half     = 1'b1;
        state_next       = S_WAIT_C2;
      end
      S_WAIT_C2: begin
        if (!status.cordic_busy && status.out_free) begin
          cmd.upd_op = UPD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/unicycle_odometry_integrator_unit.sv */
// ----------------------------------------------------------------------------
// unicycle_odometry_integrator_unit - Euler dead-reckoning pose integrator
// From request accept to out_valid: two passes through the
//   one-iteration-per-cycle CORDIC with eleven steps between them (eight
//   products on the shared 34x18 multiplier, the last accumulate, the heading
//   update, the restart), a state to see the first pass done and one to write
//   the output register, which waits while a result is stalled. A new request
//   is taken only after the previous one has been written out.
// Reset (rst, synchronous): pose cleared to origin facing +x, step_time 1311.
// ----------------------------------------------------------------------------
module unicycle_odometry_integrator_unit
  import uoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // sample tick request
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // pose result request
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // step_time register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Per tick: CORDIC on the old heading gives cos/sin; dt*v and dt*w are
  // formed, then dt*v*cos, dt*v*sin and dt*w*(2^15/pi) are built from two
  // 16-bit partial products each and rounded into x, y and heading. A second
  // CORDIC pass on half the new heading gives the yaw quaternion.

  // Config writes are to arrive only while idle (the block does not enforce this); the port is always ready.
  assign cfg_ready = 1'b1;

  uoi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  uoi_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data)
  );

  // a taken request closes the input side right after it is accepted
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input side open right after an accepted request");

  // results appear only at the end of a tick's work
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a tick in progress");

  // the CORDIC is never restarted mid-run
  a_cordic_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.cordic_start |-> !status.cordic_busy)
    else $error("CORDIC started while busy");

  // the output register is never overwritten while a result waits
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd_op == UPD_OUT) |-> (!out_valid || !out_stall))
    else $error("output register written while result stalled");

endmodule
